@@ hw/rtl/dht_single_wire_receiver_defines.svh @@
// assertion macros shared by the single-wire receiver rtl
// expects i_clk and the active-low i_rst_n in the including module
`ifndef DHT_SINGLE_WIRE_RECEIVER_DEFINES_SVH
`define DHT_SINGLE_WIRE_RECEIVER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dsr_pkg.sv @@
// types and constants for the single-wire sensor receiver
// no dependencies; used by every other rtl file but the assertion header
`default_nettype none

package dsr_pkg;

    // frame layout
    localparam int FRAME_BYTES = 5;
    localparam int FRAME_BITS  = FRAME_BYTES * 8;
    localparam int BITS_W      = $clog2(FRAME_BITS + 1);
    localparam int CFG_W       = 16;

    // register reset values
    localparam logic [CFG_W-1:0] START_LOW_RESET = 16'd18000;
    localparam logic [CFG_W-1:0] TIMEOUT_RESET   = 16'd255;
    localparam logic [CFG_W-1:0] ONE_THR_RESET   = 16'd40;

    // register indexes
    typedef enum logic [1:0] {
        REG_START_LOW = 2'd0,
        REG_TIMEOUT   = 2'd1,
        REG_ONE_THR   = 2'd2
    } t_reg_idx;

    // status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CSUM    = 2'd1,
        ST_TIMEOUT = 2'd2
    } t_status;

    // protocol phases
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_START     = 3'd1,
        PH_RESP_LOW  = 3'd2,
        PH_RESP_HIGH = 3'd3,
        PH_RESP_END  = 3'd4,
        PH_BIT_LOW   = 3'd5,
        PH_BIT_HIGH  = 3'd6
    } t_phase;

    typedef struct packed {
        logic start_request;
        logic line_level;
    } t_in_beat;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        frame_done;
        logic [1:0]  status;
        logic [15:0] humidity;
        logic [15:0] temperature;
    } t_out_beat;

    typedef struct packed {
        logic [1:0]       index;
        logic [CFG_W-1:0] data;
    } t_cfg_beat;

    // live register values
    typedef struct packed {
        logic [CFG_W-1:0] start_low_ticks;
        logic [CFG_W-1:0] timeout_ticks;
        logic [CFG_W-1:0] one_threshold_ticks;
    } t_cfg;

endpackage

`default_nettype wire

@@ hw/rtl/dsr_channels.sv @@
// valid/ready channel interfaces for sample, result and register beats
// depends on dsr_pkg
`default_nettype none

interface dsr_in_if ();
    import dsr_pkg::*;
    logic     valid;
    logic     ready;
    t_in_beat beat;
    modport source (output valid, output beat, input ready);
    modport sink   (input valid, input beat, output ready);
endinterface

interface dsr_out_if ();
    import dsr_pkg::*;
    logic      valid;
    logic      ready;
    t_out_beat beat;
    modport source (output valid, output beat, input ready);
    modport sink   (input valid, input beat, output ready);
endinterface

interface dsr_cfg_if ();
    import dsr_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_beat beat;
    modport source (output valid, output beat, input ready);
    modport sink   (input valid, input beat, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dht_single_wire_receiver.sv @@
// top level of the single-wire humidity sensor host receiver
// depends on dsr_pkg, dsr_channels, dsr_cfg_regs, dsr_frame_fsm, assertion header
//
// channel  | dir | payload                                          | role
// i_in     | in  | start_request, line_level                        | one wire sample per tick
// o_out    | out | drive_low, busy_res, frame_done, status, hum/temp | one result per sample
// i_cfg    | in  | index, data                                      | register writes, always ready
//
// one sample per cycle while results drain; a result is valid the cycle after its sample beat
// the sequencer state and the result register are the only stages
// a stalled result holds the register; a new sample is taken in the cycle it drains
// reset is synchronous and active low; registers return to their default timings
`default_nettype none
`include "dht_single_wire_receiver_defines.svh"

module dht_single_wire_receiver #(
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dsr_in_if.sink    i_in,
    dsr_out_if.source o_out,
    dsr_cfg_if.sink   i_cfg
);
    import dsr_pkg::*;

    t_cfg      cfg;
    t_out_beat res;
    logic      step;
    logic      r_out_valid, n_out_valid;
    t_out_beat r_out;

    // register writes never stall
    assign i_cfg.ready = 1'b1;

    dsr_cfg_regs u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (i_cfg.valid),
        .i_beat (i_cfg.beat),
        .o_cfg  (cfg)
    );

    // a sample is taken when the result slot is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign step       = i_in.valid && i_in.ready;

    dsr_frame_fsm #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_fsm (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (step),
        .i_beat (i_in.beat),
        .i_cfg  (cfg),
        .o_res  (res)
    );

    // result register
    always_comb begin
        if (step) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.beat  = r_out;

    // checks
    `DSR_ASSERT_NEXT(a_sample_gives_result, step, r_out_valid, "sample beat without result")
    `DSR_ASSERT_NOW(a_no_overwrite, r_out_valid && !o_out.ready, !i_in.ready, "result slot overrun")
    `DSR_ASSERT_NOW(a_status_needs_done, r_out_valid && r_out.status != ST_OK, r_out.frame_done, "status without frame end")

endmodule

`default_nettype wire

@@ hw/rtl/dsr_cfg_regs.sv @@
// configuration registers: start low time, timeout, one threshold
// depends on dsr_pkg
`default_nettype none

module dsr_cfg_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  dsr_pkg::t_cfg_beat i_beat,
    output dsr_pkg::t_cfg      o_cfg
);
    import dsr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // index decode, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (i_beat.index)
                REG_START_LOW: n_cfg.start_low_ticks     = i_beat.data;
                REG_TIMEOUT:   n_cfg.timeout_ticks       = i_beat.data;
                REG_ONE_THR:   n_cfg.one_threshold_ticks = i_beat.data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low_ticks     <= START_LOW_RESET;
            r_cfg.timeout_ticks       <= TIMEOUT_RESET;
            r_cfg.one_threshold_ticks <= ONE_THR_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ hw/rtl/dsr_frame_fsm.sv @@
// protocol sequencer: start pulse, response waits, bit timing, frame check
// depends on dsr_pkg and the assertion header
`default_nettype none
`include "dht_single_wire_receiver_defines.svh"

module dsr_frame_fsm #(
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  dsr_pkg::t_in_beat  i_beat,
    input  dsr_pkg::t_cfg      i_cfg,
    output dsr_pkg::t_out_beat o_res
);
    import dsr_pkg::*;

    localparam int CMP_W = (COUNTER_WIDTH > CFG_W) ? COUNTER_WIDTH : CFG_W;

    t_phase                  r_phase, n_phase;
    logic [COUNTER_WIDTH-1:0] r_count, n_count;
    logic [BITS_W-1:0]       r_bits, n_bits;
    logic [FRAME_BITS-1:0]   r_shift, n_shift;

    logic [COUNTER_WIDTH-1:0] count_inc;
    logic [BITS_W-1:0]       bits_inc;
    logic [FRAME_BITS-1:0]   shift_in;
    logic                    wait_fail;
    logic                    timeout_hit;
    logic                    start_over;
    logic                    bit_val;
    logic                    last_bit;
    logic [7:0]              csum;
    logic                    line;
    logic                    done_step;

    assign line = i_beat.line_level;

    // saturating tick counter and the compares against the registers
    assign count_inc   = (r_count == '1) ? r_count : r_count + 1'b1;
    assign timeout_hit = CMP_W'(count_inc) >= CMP_W'(i_cfg.timeout_ticks);
    assign start_over  = CMP_W'(count_inc) >= CMP_W'(i_cfg.start_low_ticks);
    assign bit_val     = CMP_W'(r_count) >= CMP_W'(i_cfg.one_threshold_ticks);

    // bit assembly, msb first
    assign bits_inc = r_bits + 1'b1;
    assign last_bit = bits_inc >= BITS_W'(FRAME_BITS);
    assign shift_in = {r_shift[FRAME_BITS-2:0], bit_val};
    assign csum     = shift_in[39:32] + shift_in[31:24] + shift_in[23:16] + shift_in[15:8];

    // awaited level not seen this tick
    always_comb begin
        case (r_phase) inside
            PH_RESP_LOW, PH_RESP_END: wait_fail = line;
            PH_RESP_HIGH, PH_BIT_LOW: wait_fail = !line;
            PH_BIT_HIGH:              wait_fail = line;
            default:                  wait_fail = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_bits  = r_bits;
        n_shift = r_shift;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_beat.start_request) begin
                    n_phase = PH_START;
                    n_count = '0;
                    n_bits  = '0;
                    n_shift = '0;
                end
            end
            PH_START: begin
                if (start_over) begin
                    n_phase = PH_RESP_LOW;
                    n_count = '0;
                end else begin
                    n_count = count_inc;
                end
            end
            PH_RESP_LOW: begin
                if (!line) begin
                    n_phase = PH_RESP_HIGH;
                    n_count = '0;
                end
            end
            PH_RESP_HIGH: begin
                if (line) begin
                    n_phase = PH_RESP_END;
                    n_count = '0;
                end
            end
            PH_RESP_END: begin
                if (!line) begin
                    n_phase = PH_BIT_LOW;
                    n_count = '0;
                end
            end
            PH_BIT_LOW: begin
                if (line) begin
                    n_phase = PH_BIT_HIGH;
                    n_count = COUNTER_WIDTH'(1);
                end
            end
            PH_BIT_HIGH: begin
                if (!line) begin
                    n_shift = shift_in;
                    n_bits  = bits_inc;
                    n_phase = last_bit ? PH_IDLE : PH_BIT_LOW;
                    n_count = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_count = '0;
            end
        endcase
        // any wait phase that overstays ends the frame
        if (wait_fail) begin
            if (timeout_hit) begin
                n_phase = PH_IDLE;
                n_count = '0;
            end else begin
                n_count = count_inc;
            end
        end
    end

    // result fields
    always_comb begin
        o_res = '0;
        o_res.busy_res = (n_phase != PH_IDLE);
        unique case (r_phase)
            PH_IDLE:  o_res.drive_low = i_beat.start_request;
            PH_START: o_res.drive_low = !start_over;
            PH_BIT_HIGH: begin
                if (!line && last_bit) begin
                    o_res.frame_done  = 1'b1;
                    o_res.humidity    = shift_in[39:24];
                    o_res.temperature = shift_in[23:8];
                    o_res.status      = (csum == shift_in[7:0]) ? ST_OK : ST_CSUM;
                end
            end
            default: o_res.drive_low = 1'b0;
        endcase
        if (wait_fail && timeout_hit) begin
            o_res.frame_done  = 1'b1;
            o_res.status      = ST_TIMEOUT;
            o_res.humidity    = '0;
            o_res.temperature = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_bits  <= '0;
            r_shift <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_bits  <= n_bits;
            r_shift <= n_shift;
        end
    end

    // checks
    assign done_step = i_step && o_res.frame_done;

    `DSR_ASSERT_NOW(a_drive_only_start, o_res.drive_low, r_phase <= PH_START, "stray drive")
    `DSR_ASSERT_NEXT(a_done_goes_idle, done_step, r_phase == PH_IDLE, "not idle after frame end")
    `DSR_ASSERT_NOW(a_bits_bounded, 1'b1, r_bits <= BITS_W'(FRAME_BITS), "bit count overrun")

endmodule

`default_nettype wire
